// ===== hdl/ptdh_pkg.sv =====
// Shared types and constants for the periodic task deadline heap.
`default_nettype none
package ptdh_pkg;

  localparam int HEAP_DEPTH_DEF   = 128;
  localparam int TASK_ID_BITS_DEF = 8;
  localparam int OCC_W_DEF        = 8;
  localparam int MS_W             = 32;
  localparam int NS_W             = 64;
  localparam int NS_PER_MS        = 1000000;
  localparam int SCALE_W          = 20;
  localparam int PROD_W           = MS_W + SCALE_W;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD      = 2'd0;
  localparam cmd_t CMD_DISPATCH = 2'd1;
  localparam cmd_t CMD_CLEAR    = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_MUL,
    S_A_SUM,
    S_D_ROOT,
    S_D_MUL,
    S_D_SUM,
    S_DN_CHECK,
    S_DN_PICK,
    S_DN_CMP,
    S_UP_CHECK,
    S_UP_CMP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/ptdh_if.sv =====
// Command and result channel interfaces of the deadline heap.
`default_nettype none
interface ptdh_in_if #(
  parameter int TASK_ID_BITS = ptdh_pkg::TASK_ID_BITS_DEF
);
  import ptdh_pkg::*;
  logic                    valid;
  logic                    ready;
  cmd_t                    cmd;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [NS_W-1:0]         now_ns;
  logic [MS_W-1:0]         delay_ms;
  logic [MS_W-1:0]         period_ms;

  modport source (output valid, cmd, task_id, now_ns, delay_ms, period_ms, input ready);
  modport sink   (input valid, cmd, task_id, now_ns, delay_ms, period_ms, output ready);
endinterface

interface ptdh_out_if #(
  parameter int TASK_ID_BITS = ptdh_pkg::TASK_ID_BITS_DEF,
  parameter int OCC_W        = ptdh_pkg::OCC_W_DEF
);
  import ptdh_pkg::*;
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [TASK_ID_BITS-1:0] out_task;
  logic [NS_W-1:0]         scheduled_ns;
  logic [NS_W-1:0]         next_ns;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, status, out_task, scheduled_ns, next_ns, occupancy,
                  input ready);
  modport sink   (input valid, status, out_task, scheduled_ns, next_ns, occupancy,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/periodic_task_deadline_heap_unit.sv =====
// Top level: binary min-heap of periodic task deadlines with an add/dispatch/clear sequencer.
// Add: deadline is now + delay, sifted up past later parents; a full heap reports full.
// Dispatch: pops the root, sifts the last entry down past earlier children, then re-adds
// the task at its deadline + period by sifting up. Clear, empty dispatch and unused codes
// go straight to the result. A new command is taken only after the result is registered.
// Reset empties the heap at once (count cleared); heap contents are not touched.
`default_nettype none
module periodic_task_deadline_heap_unit #(
  parameter int HEAP_DEPTH   = ptdh_pkg::HEAP_DEPTH_DEF,
  parameter int TASK_ID_BITS = ptdh_pkg::TASK_ID_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ptdh_in_if.sink   in_ch,
  ptdh_out_if.source out_ch
);
  import ptdh_pkg::*;

  localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int IDX_W  = ADDR_W + 1;
  localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int ENT_W  = TASK_ID_BITS + MS_W + NS_W;
  localparam int PER_LO = NS_W;
  localparam int TSK_LO = NS_W + MS_W;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HEAP_DEPTH);

  // heap storage: {task, period, deadline}
  logic [ENT_W-1:0] mem [HEAP_DEPTH];

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  status_t                 status_r, status_nxt;
  logic [TASK_ID_BITS-1:0] task_r, task_nxt;
  logic [MS_W-1:0]         period_r, period_nxt;
  logic [MS_W-1:0]         delay_r, delay_nxt;
  logic [NS_W-1:0]         now_r, now_nxt;
  logic [NS_W-1:0]         sched_r, sched_nxt;
  logic [NS_W-1:0]         next_r, next_nxt;
  logic [ENT_W-1:0]        key_r, key_nxt;
  logic [ENT_W-1:0]        pick_r, pick_nxt;
  logic [ADDR_W-1:0]       pick_idx_r, pick_idx_nxt;
  logic [ADDR_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [TASK_ID_BITS-1:0] out_task_r, out_task_nxt;
  logic [NS_W-1:0]         out_sched_r, out_sched_nxt;
  logic [NS_W-1:0]         out_next_r, out_next_nxt;
  logic [CNT_W-1:0]        out_occ_r, out_occ_nxt;

  logic [ENT_W-1:0]  rd0_r, rd1_r;
  logic [ADDR_W-1:0] raddr0, raddr1, waddr;
  logic              mem_we;
  logic [ENT_W-1:0]  wdata;

  logic              mul_en;
  logic [MS_W-1:0]   mul_a;
  logic [NS_W-1:0]   add_a, cmp_a, cmp_b, alu_sum;
  logic              alu_lt;

  logic [IDX_W-1:0]  left_idx, right_idx, cnt_ext;
  logic [ADDR_W-1:0] up_idx;
  logic              in_acc, out_free, dispatch_ok;

  assign left_idx  = {pos_r, 1'b1};
  assign right_idx = left_idx + IDX_W'(1);
  assign cnt_ext   = IDX_W'(count_r);
  assign up_idx    = (pos_r - ADDR_W'(1)) >> 1;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign dispatch_ok = (cmd_r == CMD_DISPATCH) && (status_r == STAT_DONE);

  ptdh_alu u_alu (
    .clk    (clk),
    .mul_en (mul_en),
    .mul_a  (mul_a),
    .add_a  (add_a),
    .cmp_a  (cmp_a),
    .cmp_b  (cmp_b),
    .sum    (alu_sum),
    .lt     (alu_lt)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    task_nxt       = task_r;
    period_nxt     = period_r;
    delay_nxt      = delay_r;
    now_nxt        = now_r;
    sched_nxt      = sched_r;
    next_nxt       = next_r;
    key_nxt        = key_r;
    pick_nxt       = pick_r;
    pick_idx_nxt   = pick_idx_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_sched_nxt  = out_sched_r;
    out_next_nxt   = out_next_r;
    out_occ_nxt    = out_occ_r;
    raddr0         = '0;
    raddr1         = '0;
    waddr          = pos_r;
    mem_we         = 1'b0;
    wdata          = key_r;
    mul_en         = 1'b0;
    mul_a          = delay_r;
    add_a          = now_r;
    cmp_a          = key_r[NS_W-1:0];
    cmp_b          = rd0_r[NS_W-1:0];

    case (state_r)
      S_IDLE: begin
        // root read issued here so a dispatch sees it next cycle
        raddr0 = '0;
        if (in_acc) begin
          cmd_nxt    = in_ch.cmd;
          task_nxt   = in_ch.task_id;
          now_nxt    = in_ch.now_ns;
          delay_nxt  = in_ch.delay_ms;
          period_nxt = in_ch.period_ms;
          status_nxt = STAT_DONE;
          case (in_ch.cmd)
            CMD_ADD: state_nxt = S_A_MUL;
            CMD_DISPATCH: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_D_ROOT;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_A_MUL: begin
        mul_en    = 1'b1;
        mul_a     = delay_r;
        state_nxt = S_A_SUM;
      end
      S_A_SUM: begin
        add_a     = now_r;
        sched_nxt = alu_sum;
        if (count_r == FULL_CNT) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_DONE;
        end else begin
          key_nxt   = {task_r, period_r, alu_sum};
          pos_nxt   = ADDR_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_UP_CHECK;
        end
      end
      S_D_ROOT: begin
        task_nxt   = rd0_r[TSK_LO +: TASK_ID_BITS];
        period_nxt = rd0_r[PER_LO +: MS_W];
        sched_nxt  = rd0_r[NS_W-1:0];
        state_nxt  = S_D_MUL;
      end
      S_D_MUL: begin
        mul_en    = 1'b1;
        mul_a     = period_r;
        raddr0    = ADDR_W'(count_r - CNT_W'(1));
        state_nxt = S_D_SUM;
      end
      S_D_SUM: begin
        add_a     = sched_r;
        next_nxt  = alu_sum;
        key_nxt   = rd0_r;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = '0;
        state_nxt = S_DN_CHECK;
      end
      S_DN_CHECK: begin
        if (left_idx < cnt_ext) begin
          raddr0    = left_idx[ADDR_W-1:0];
          raddr1    = right_idx[ADDR_W-1:0];
          state_nxt = S_DN_PICK;
        end else begin
          mem_we    = 1'b1;
          wdata     = key_r;
          key_nxt   = {task_r, period_r, next_r};
          pos_nxt   = ADDR_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_UP_CHECK;
        end
      end
      S_DN_PICK: begin
        // right child only when strictly earlier
        cmp_a = rd1_r[NS_W-1:0];
        cmp_b = rd0_r[NS_W-1:0];
        if ((right_idx < cnt_ext) && alu_lt) begin
          pick_nxt     = rd1_r;
          pick_idx_nxt = right_idx[ADDR_W-1:0];
        end else begin
          pick_nxt     = rd0_r;
          pick_idx_nxt = left_idx[ADDR_W-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmp_a  = key_r[NS_W-1:0];
        cmp_b  = pick_r[NS_W-1:0];
        mem_we = 1'b1;
        if (alu_lt) begin
          wdata     = key_r;
          key_nxt   = {task_r, period_r, next_r};
          pos_nxt   = ADDR_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_UP_CHECK;
        end else begin
          wdata     = pick_r;
          pos_nxt   = pick_idx_r;
          state_nxt = S_DN_CHECK;
        end
      end
      S_UP_CHECK: begin
        if (pos_r != '0) begin
          raddr0    = up_idx;
          state_nxt = S_UP_CMP;
        end else begin
          mem_we    = 1'b1;
          wdata     = key_r;
          state_nxt = S_DONE;
        end
      end
      S_UP_CMP: begin
        // equal parent stays above
        cmp_a  = key_r[NS_W-1:0];
        cmp_b  = rd0_r[NS_W-1:0];
        mem_we = 1'b1;
        if (alu_lt) begin
          wdata     = rd0_r;
          pos_nxt   = up_idx;
          state_nxt = S_UP_CHECK;
        end else begin
          wdata     = key_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_task_nxt   = dispatch_ok ? task_r : '0;
          out_sched_nxt  = (dispatch_ok || cmd_r == CMD_ADD) ? sched_r : '0;
          out_next_nxt   = dispatch_ok ? next_r : '0;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    task_r       <= task_nxt;
    period_r     <= period_nxt;
    delay_r      <= delay_nxt;
    now_r        <= now_nxt;
    sched_r      <= sched_nxt;
    next_r       <= next_nxt;
    key_r        <= key_nxt;
    pick_r       <= pick_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_sched_r  <= out_sched_nxt;
    out_next_r   <= out_next_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_task     = out_task_r;
  assign out_ch.scheduled_ns = out_sched_r;
  assign out_ch.next_ns      = out_next_r;
  assign out_ch.occupancy    = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("heap count above depth");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_FULL) |-> (out_occ_r == FULL_CNT))
    else $error("full status with heap not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_EMPTY) |-> (out_occ_r == '0))
    else $error("empty status with entries left");

  a_sift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_CHECK || state_r == S_UP_CMP) |-> (IDX_W'(pos_r) < cnt_ext))
    else $error("sift-up position outside heap");

  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("heap write outside a command");

endmodule
`default_nettype wire

// ===== hdl/ptdh_alu.sv =====
// Shared arithmetic unit: ms-to-ns multiply (registered), 64-bit add and unsigned compare.
`default_nettype none
module ptdh_alu (
  input  wire logic                   clk,
  input  wire logic                   mul_en,
  input  wire logic [ptdh_pkg::MS_W-1:0] mul_a,
  input  wire logic [ptdh_pkg::NS_W-1:0] add_a,
  input  wire logic [ptdh_pkg::NS_W-1:0] cmp_a,
  input  wire logic [ptdh_pkg::NS_W-1:0] cmp_b,
  output logic      [ptdh_pkg::NS_W-1:0] sum,
  output logic                           lt
);
  import ptdh_pkg::*;

  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(NS_PER_MS);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(SCALE);
    end
  end

  // sum wraps modulo 2^64
  assign sum = add_a + NS_W'(prod_r);
  assign lt  = (cmp_a < cmp_b);

endmodule
`default_nettype wire
